/* hw/rtl/rsi_pkg.sv */
package rsi_pkg;

   localparam int PERIOD_W   = 11;
   localparam int PRICE_IN_W = 32;
   localparam int VALUE_W    = 14;
   localparam int PM1_W      = 10;
   localparam int SCALE_W    = 14;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd14;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 11'd2;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 11'd1024;
   localparam logic [PERIOD_W-1:0] SEEDED_MARK  = 11'd2047;

   // 100 * 100: full scale in hundredths
   localparam logic [SCALE_W-1:0] RSI_SCALE = 14'd10000;
   localparam logic [VALUE_W-1:0] RSI_FULL  = 14'd10000;

   typedef struct packed {
      logic [PRICE_IN_W-1:0] close_price;
      logic                  series_start;
   } req_type;

   typedef struct packed {
      logic               rsi_valid;
      logic [VALUE_W-1:0] rsi_value;
   } rsp_type;

   typedef enum logic [1:0] {
      DIV_GAIN,
      DIV_LOSS,
      DIV_RSI
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_DG_GO,
      ST_DG_WAIT,
      ST_DL_GO,
      ST_DL_WAIT,
      ST_RSI_PREP,
      ST_DR_GO,
      ST_DR_WAIT,
      ST_EMIT,
      ST_EMIT_ZERO
   } state_type;

   typedef struct packed {
      logic        take_req;
      logic        step;
      logic        mul;
      logic        add;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_gain;
      logic        cap_loss;
      logic        rsi_prep;
      logic        emit_zero;
      logic        emit_rsi;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic seeded;
      logic warm_full;
      logic loss_zero;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/rsi_wilder_stream_top.sv */
// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_ready  req_type: close_price, series_start
// rsp_*     out        rsp_valid/rsp_ready  rsp_type: rsi_valid, rsi_value
// csr_*     in         csr_wr_en            csr_wr_data: period (11 bits)
//
// A request that restarts a series or falls in warm-up emits an invalid zero result after the diff step.
// A smoothed request runs scale, add, gain and loss divides, RSI prep, RSI
// divide and emit; NUMW, the divider width, is min(PRICE_BITS + FRAC_BITS
// + 24, 64). The RSI divide is skipped when the average loss is zero;
// the shared one-bit-per-cycle divider runs gain, loss and RSI.
// Reset is synchronous; it restores period 14 and drops any series.
// The result register frees the input side: a new request is taken while
// a result waits, and a finished result holds until rsp_ready.
module rsi_wilder_stream_top #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rsi_pkg::req_type             req_payload,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rsi_pkg::rsp_type             rsp_payload,
   // period register
   input  logic                         csr_wr_en,
   input  logic [rsi_pkg::PERIOD_W-1:0] csr_wr_data
);

   rsi_pkg::cmd_type    cmd;
   rsi_pkg::status_type status;

   // sequence each request through diff, then scale and divide unless restarting or warming up, then emit
   rsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold series state, averages, divider and the result register
   rsi_dpath #(
      .PRICE_BITS(PRICE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* hw/rtl/rsi_div.sv */
module rsi_div #(
   parameter int NW = 64,
   parameter int VW = 59
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [VW:0] trial;
   logic [VW:0] diff;
   logic        ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, q_ff[NW-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = (trial >= {1'b0, div_ff});
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NW-2:0], ge};
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/rsi_dpath.sv */
module rsi_dpath #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rsi_pkg::req_type             req_payload,
   input  logic                         csr_wr_en,
   input  logic [rsi_pkg::PERIOD_W-1:0] csr_wr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output rsi_pkg::rsp_type             rsp_payload,
   input  rsi_pkg::cmd_type             cmd,
   output rsi_pkg::status_type          status
);

   localparam int AW_RAW   = PRICE_BITS + FRAC_BITS + 10;
   localparam int AW       = (AW_RAW > 64) ? 64 : AW_RAW;
   localparam int NUMW     = (AW + 14 > 64) ? 64 : AW + 14;
   localparam int DENW     = (AW + 1 > 64) ? 64 : AW + 1;
   localparam int PW       = rsi_pkg::PERIOD_W;

   logic [PW-1:0]         period_ff;
   logic [PRICE_BITS-1:0] price_ff, last_ff;
   logic                  start_ff, have_last_ff;
   logic [PRICE_BITS-1:0] gain_ff, loss_ff;
   logic [AW-1:0]         avg_gain_ff, avg_loss_ff;
   logic [PW-1:0]         cnt_ff;
   logic [AW-1:0]         prod_g_ff, prod_l_ff;
   logic [AW-1:0]         dvd_g_ff, dvd_l_ff;
   logic [NUMW-1:0]       num_ff;
   logic [DENW-1:0]       den_ff;
   logic                  rsp_valid_ff;
   rsi_pkg::rsp_type      rsp_ff;

   logic [63:0]                  close_wide;
   logic [PW-1:0]                p;
   logic [rsi_pkg::PM1_W-1:0]    pm1;
   logic                         up;
   logic [PRICE_BITS-1:0]        gain, loss;
   logic                         seeding;
   logic [PRICE_BITS+FRAC_BITS-1:0] gain_sh, loss_sh;
   logic [AW+FRAC_BITS-1:0]      sum_g_sh, sum_l_sh;
   logic [NUMW-1:0]              div_dividend;
   logic [DENW-1:0]              div_divisor;
   logic [NUMW-1:0]              div_q;
   logic                         div_done;

   assign close_wide = {32'b0, req_payload.close_price};

   always_comb begin
      if (period_ff < rsi_pkg::PERIOD_MIN) begin
         p = rsi_pkg::PERIOD_MIN;
      end else if (period_ff > rsi_pkg::PERIOD_MAX) begin
         p = rsi_pkg::PERIOD_MAX;
      end else begin
         p = period_ff;
      end
   end

   assign pm1      = rsi_pkg::PM1_W'(p - 1'b1);
   assign up       = (price_ff > last_ff);
   assign gain     = up ? (price_ff - last_ff) : '0;
   assign loss     = up ? '0 : (last_ff - price_ff);
   assign seeding  = (cnt_ff != rsi_pkg::SEEDED_MARK);
   assign gain_sh  = {gain_ff, {FRAC_BITS{1'b0}}};
   assign loss_sh  = {loss_ff, {FRAC_BITS{1'b0}}};
   assign sum_g_sh = {avg_gain_ff, {FRAC_BITS{1'b0}}};
   assign sum_l_sh = {avg_loss_ff, {FRAC_BITS{1'b0}}};

   always_comb begin
      case (cmd.div_sel)
         rsi_pkg::DIV_GAIN: begin
            div_dividend = NUMW'(dvd_g_ff);
            div_divisor  = DENW'(p);
         end
         rsi_pkg::DIV_LOSS: begin
            div_dividend = NUMW'(dvd_l_ff);
            div_divisor  = DENW'(p);
         end
         rsi_pkg::DIV_RSI: begin
            div_dividend = num_ff;
            div_divisor  = den_ff;
         end
         default: begin
            div_dividend = num_ff;
            div_divisor  = den_ff;
         end
      endcase
   end

   rsi_div #(
      .NW(NUMW),
      .VW(DENW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         price_ff <= close_wide[PRICE_BITS-1:0];
         start_ff <= req_payload.series_start;
      end
      if (cmd.step) begin
         last_ff <= price_ff;
         gain_ff <= gain;
         loss_ff <= loss;
         if (start_ff || !have_last_ff) begin
            avg_gain_ff <= '0;
            avg_loss_ff <= '0;
            cnt_ff      <= '0;
         end else if (seeding) begin
            avg_gain_ff <= avg_gain_ff + AW'(gain);
            avg_loss_ff <= avg_loss_ff + AW'(loss);
            cnt_ff      <= cnt_ff + 1'b1;
         end
      end
      // seed from the warm-up sums, or scale the running averages
      if (cmd.mul) begin
         if (seeding) begin
            prod_g_ff <= sum_g_sh[AW-1:0];
            prod_l_ff <= sum_l_sh[AW-1:0];
         end else begin
            prod_g_ff <= AW'(avg_gain_ff * pm1);
            prod_l_ff <= AW'(avg_loss_ff * pm1);
         end
      end
      if (cmd.add) begin
         if (seeding) begin
            dvd_g_ff <= prod_g_ff;
            dvd_l_ff <= prod_l_ff;
         end else begin
            dvd_g_ff <= prod_g_ff + AW'(gain_sh);
            dvd_l_ff <= prod_l_ff + AW'(loss_sh);
         end
      end
      if (cmd.cap_gain) begin
         avg_gain_ff <= div_q[AW-1:0];
      end
      if (cmd.cap_loss) begin
         avg_loss_ff <= div_q[AW-1:0];
         cnt_ff      <= rsi_pkg::SEEDED_MARK;
      end
      if (cmd.rsi_prep) begin
         num_ff <= NUMW'(avg_gain_ff * rsi_pkg::RSI_SCALE);
         den_ff <= DENW'({1'b0, avg_gain_ff} + {1'b0, avg_loss_ff});
      end
      if (cmd.emit_zero) begin
         rsp_ff.rsi_valid <= 1'b0;
         rsp_ff.rsi_value <= '0;
      end else if (cmd.emit_rsi) begin
         rsp_ff.rsi_valid <= 1'b1;
         rsp_ff.rsi_value <= (avg_loss_ff == '0) ? rsi_pkg::RSI_FULL
                                                 : div_q[rsi_pkg::VALUE_W-1:0];
      end

      if (reset) begin
         period_ff    <= rsi_pkg::PERIOD_RESET;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (cmd.step) begin
            have_last_ff <= 1'b1;
         end
         if (cmd.emit_zero || cmd.emit_rsi) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.restart   = start_ff || !have_last_ff;
      status.seeded    = !seeding;
      status.warm_full = ((cnt_ff + 1'b1) >= p);
      status.loss_zero = (avg_loss_ff == '0);
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/rsi_ctrl.sv */
module rsi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rsi_pkg::status_type status,
   output rsi_pkg::cmd_type    cmd
);

   rsi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.div_sel = rsi_pkg::DIV_GAIN;
      case (state_ff)
         rsi_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = rsi_pkg::ST_DIFF;
            end
         end
         rsi_pkg::ST_DIFF: begin
            cmd.step = 1'b1;
            if (status.restart) begin
               state_in = rsi_pkg::ST_EMIT_ZERO;
            end else if (!status.seeded && !status.warm_full) begin
               state_in = rsi_pkg::ST_EMIT_ZERO;
            end else begin
               state_in = rsi_pkg::ST_MUL;
            end
         end
         rsi_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = rsi_pkg::ST_ADD;
         end
         rsi_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = rsi_pkg::ST_DG_GO;
         end
         rsi_pkg::ST_DG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rsi_pkg::DIV_GAIN;
            state_in      = rsi_pkg::ST_DG_WAIT;
         end
         rsi_pkg::ST_DG_WAIT: begin
            cmd.div_sel = rsi_pkg::DIV_GAIN;
            if (status.div_done) begin
               cmd.cap_gain = 1'b1;
               state_in     = rsi_pkg::ST_DL_GO;
            end
         end
         rsi_pkg::ST_DL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rsi_pkg::DIV_LOSS;
            state_in      = rsi_pkg::ST_DL_WAIT;
         end
         rsi_pkg::ST_DL_WAIT: begin
            cmd.div_sel = rsi_pkg::DIV_LOSS;
            if (status.div_done) begin
               cmd.cap_loss = 1'b1;
               state_in     = rsi_pkg::ST_RSI_PREP;
            end
         end
         rsi_pkg::ST_RSI_PREP: begin
            cmd.rsi_prep = 1'b1;
            if (status.loss_zero) begin
               state_in = rsi_pkg::ST_EMIT;
            end else begin
               state_in = rsi_pkg::ST_DR_GO;
            end
         end
         rsi_pkg::ST_DR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rsi_pkg::DIV_RSI;
            state_in      = rsi_pkg::ST_DR_WAIT;
         end
         rsi_pkg::ST_DR_WAIT: begin
            cmd.div_sel = rsi_pkg::DIV_RSI;
            if (status.div_done) begin
               state_in = rsi_pkg::ST_EMIT;
            end
         end
         rsi_pkg::ST_EMIT: begin
            cmd.div_sel = rsi_pkg::DIV_RSI;
            if (status.out_free) begin
               cmd.emit_rsi = 1'b1;
               state_in     = rsi_pkg::ST_IDLE;
            end
         end
         rsi_pkg::ST_EMIT_ZERO: begin
            if (status.out_free) begin
               cmd.emit_zero = 1'b1;
               state_in      = rsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
